// ===== rtl/core/fer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fer_pkg
// Types, constants and fault tables shared by the fault event recorder.
// ----------------------------------------------------------------------------
package fer_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int NUM_FAULTS  = 14;
  localparam int NUM_GROUPS  = 10;
  localparam int FAULT_W     = 4;
  localparam int NEW_W       = 16;
  localparam int LIMIT_W     = 16;
  localparam int SUPPLY_W    = 12;
  localparam int WARN_W      = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int GROUP_IDX_W = 4;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 16'd65535;
  localparam logic [SUPPLY_W-1:0] THRESHOLD_RESET = 12'd1840;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_THRESHOLD = 2'd1;

  typedef struct packed {
    logic [WARN_W-1:0]   warn_mask;
    logic                selftest_error;
    logic                link_error;
    logic [SUPPLY_W-1:0] supply_raw;
  } fer_in_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_id;
    logic [NEW_W-1:0]   new_count;
    logic               last;
  } fer_out_t;

  // Latch that guards each fault.
  function automatic logic [GROUP_IDX_W-1:0] fault_group(logic [FAULT_W-1:0] f);
    logic [GROUP_IDX_W-1:0] g;
    case (f)
      4'd0:    g = 4'd0;
      4'd1:    g = 4'd1;
      4'd2:    g = 4'd2;
      4'd3:    g = 4'd3;
      4'd4:    g = 4'd3;
      4'd5:    g = 4'd4;
      4'd6:    g = 4'd4;
      4'd7:    g = 4'd5;
      4'd8:    g = 4'd5;
      4'd9:    g = 4'd6;
      4'd10:   g = 4'd9;
      4'd11:   g = 4'd9;
      4'd12:   g = 4'd7;
      4'd13:   g = 4'd8;
      default: g = 4'd0;
    endcase
    return g;
  endfunction

  // Fault handled at each position of the record order.
  function automatic logic [FAULT_W-1:0] order_fault(logic [FAULT_W-1:0] p);
    logic [FAULT_W-1:0] f;
    case (p)
      4'd10:   f = 4'd12;
      4'd11:   f = 4'd13;
      4'd12:   f = 4'd10;
      4'd13:   f = 4'd11;
      default: f = p;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/fault_event_recorder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fault_event_recorder
// Counts fault occurrences per fault, gated by its group latch, and emits one record per increment.
// ----------------------------------------------------------------------------
// Records: each record waits in the hold register until its last flag is known,
//   and only then moves on to the output register.
// Throughput: ticks with no active fault under a clear latch are taken one per cycle
//   while the tick buffer is empty; otherwise one fault per cycle, plus any output stall.
// Reset: asynchronous, active low; latches clear, the counter entries read as
//   zero through per-entry valid bits, and the registers take their defaults.
// ----------------------------------------------------------------------------
module fault_event_recorder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fer_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fer_pkg::fer_in_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fer_pkg::fer_out_t           out_req_o
);
  import fer_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  // Configuration registers.
  logic [LIMIT_W-1:0]  limit_q;
  logic [SUPPLY_W-1:0] thresh_q;

  // Group latches and the one-deep tick buffer. The buffer holds the set of
  // faults that count on a tick, already in record order.
  logic [NUM_GROUPS-1:0] latch_q, latch_d;
  logic                  buf_valid_q, buf_valid_d;
  logic [NUM_FAULTS-1:0] buf_q, buf_d;

  // Candidates of the tick under work, in record order.
  logic [NUM_FAULTS-1:0] cand_q, cand_d;

  // Counter memory and its valid bits.
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]  vld_q;
  logic [COUNT_WIDTH-1:0] rd_data_q;

  // Second stage: the read data of one fault arrives here.
  logic                   b_valid_q, b_valid_d;
  logic [FAULT_W-1:0]     b_fault_q;
  logic                   b_eot_q;
  logic                   b_ent_vld_q;
  logic                   fwd_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  // Hold register for the newest record, and the output register.
  logic               hold_valid_q, hold_valid_d;
  logic               hold_last_q, hold_last_d;
  logic [FAULT_W-1:0] hold_fault_q, hold_fault_d;
  logic [NEW_W-1:0]   hold_count_q, hold_count_d;
  logic               out_valid_q, out_valid_d;
  fer_out_t           out_q, out_d;

  // ---------------------------------------------------------------------------
  // Tick acceptance. The latch of a group after a tick simply follows whether
  // any member was active, and a fault counts when it is active while its
  // latch was clear before the tick. Ticks with a low supply change nothing.
  // ---------------------------------------------------------------------------
  logic                  in_take;
  logic                  supply_ok;
  logic [NUM_FAULTS-1:0] active;
  logic [NUM_FAULTS-1:0] countable;
  logic [NUM_FAULTS-1:0] countable_ord;
  logic [NUM_GROUPS-1:0] any_active;

  assign in_stall_o = buf_valid_q;
  assign in_take    = in_valid_i && !buf_valid_q;
  assign supply_ok  = (in_req_i.supply_raw >= thresh_q);
  assign active     = {in_req_i.link_error, in_req_i.selftest_error, in_req_i.warn_mask};

  always_comb begin
    any_active = '0;
    for (int f = 0; f < NUM_FAULTS; f++) begin
      if (active[f]) begin
        any_active[fault_group(FAULT_W'(f))] = 1'b1;
      end
      countable[f] = active[f] && !latch_q[fault_group(FAULT_W'(f))];
    end
    for (int p = 0; p < NUM_FAULTS; p++) begin
      countable_ord[p] = countable[order_fault(FAULT_W'(p))];
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: pick the first remaining candidate and read its counter.
  // The candidate set reloads from the buffer once it runs empty.
  // ---------------------------------------------------------------------------
  logic                  a_go;
  logic                  b_take;
  logic [NUM_FAULTS-1:0] pick_oh;
  logic [FAULT_W-1:0]    pick_pos;
  logic [FAULT_W-1:0]    a_fault;
  logic                  a_eot;
  logic [NUM_FAULTS-1:0] cand_left;

  always_comb begin
    pick_oh  = cand_q & (~cand_q + NUM_FAULTS'(1));
    pick_pos = '0;
    for (int p = NUM_FAULTS - 1; p >= 0; p--) begin
      if (cand_q[p]) begin
        pick_pos = FAULT_W'(p);
      end
    end
  end

  assign a_fault   = order_fault(pick_pos);
  assign a_eot     = ((cand_q & ~pick_oh) == '0);
  assign a_go      = (cand_q != '0) && (!b_valid_q || b_take);
  assign cand_left = a_go ? (cand_q & ~pick_oh) : cand_q;

  always_comb begin
    latch_d     = latch_q;
    buf_valid_d = buf_valid_q;
    buf_d       = buf_q;
    cand_d      = cand_left;
    if (cand_left == '0 && buf_valid_q) begin
      cand_d      = buf_q;
      buf_valid_d = 1'b0;
    end
    if (in_take && supply_ok) begin
      latch_d = any_active;
      if (countable_ord != '0) begin
        buf_valid_d = 1'b1;
        buf_d       = countable_ord;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Modify stage: saturating increment and write-back. A write to the entry
  // being read in the same cycle is forwarded into the next stage.
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   inc;
  logic                   mem_we;
  logic                   need_emit;
  logic                   emit;
  logic                   emit_last;
  logic                   out_free;

  assign cnt     = fwd_q ? fwd_data_q : (b_ent_vld_q ? rd_data_q : '0);
  assign cnt_inc = cnt + COUNT_WIDTH'(1);
  assign inc     = (CMP_W'(cnt) < CMP_W'(limit_q)) && (cnt != '1);

  assign out_free  = !out_valid_q || !out_stall_i;
  // The held record leaves when a newer record replaces it, when its tick
  // ends, or at once when it is already known to be the last of its tick.
  assign need_emit = hold_valid_q && (hold_last_q || (b_valid_q && (inc || b_eot_q)));
  assign emit      = need_emit && out_free;
  assign emit_last = hold_last_q || (b_valid_q && b_eot_q && !inc);
  assign b_take    = b_valid_q && (!need_emit || out_free);
  assign mem_we    = b_take && inc;

  always_comb begin
    b_valid_d = a_go ? 1'b1 : (b_take ? 1'b0 : b_valid_q);

    hold_valid_d = hold_valid_q;
    hold_last_d  = hold_last_q;
    hold_fault_d = hold_fault_q;
    hold_count_d = hold_count_q;
    if (emit) begin
      hold_valid_d = 1'b0;
    end
    if (mem_we) begin
      hold_valid_d = 1'b1;
      hold_last_d  = b_eot_q;
      hold_fault_d = b_fault_q;
      hold_count_d = NEW_W'(cnt_inc);
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d     = 1'b1;
      out_d.fault_id  = hold_fault_q;
      out_d.new_count = hold_count_q;
      out_d.last      = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RESET;
      thresh_q     <= THRESHOLD_RESET;
      latch_q      <= '0;
      buf_valid_q  <= 1'b0;
      cand_q       <= '0;
      vld_q        <= '0;
      b_valid_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RECORD_LIMIT:     limit_q  <= cfg_data_i[LIMIT_W-1:0];
          REG_SUPPLY_THRESHOLD: thresh_q <= cfg_data_i[SUPPLY_W-1:0];
          default: ;
        endcase
      end
      latch_q      <= latch_d;
      buf_valid_q  <= buf_valid_d;
      cand_q       <= cand_d;
      if (mem_we) begin
        vld_q[b_fault_q] <= 1'b1;
      end
      b_valid_q    <= b_valid_d;
      hold_valid_q <= hold_valid_d;
      hold_last_q  <= hold_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q        <= buf_d;
    hold_fault_q <= hold_fault_d;
    hold_count_q <= hold_count_d;
    out_q        <= out_d;
    if (a_go) begin
      b_fault_q   <= a_fault;
      b_eot_q     <= a_eot;
      b_ent_vld_q <= vld_q[a_fault];
      fwd_q       <= mem_we && (b_fault_q == a_fault);
      fwd_data_q  <= cnt_inc;
    end
  end

  // Counter memory: one write port from the modify stage, one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[b_fault_q] <= cnt_inc;
    end
    if (a_go) begin
      rd_data_q <= cnt_mem[a_fault];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A record is only produced by an increment, so its count is never zero.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.new_count != '0))
    else $error("record with zero count");

  // Only the fourteen defined faults are ever reported.
  a_fault_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.fault_id < FAULT_W'(NUM_FAULTS)))
    else $error("record with undefined fault id");

  // A held record not yet marked last must still have its tick in progress.
  a_hold_tick_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !hold_last_q) |-> (b_valid_q || (cand_q != '0)))
    else $error("held record lost its end of tick");

  // The counter is written only from a live second stage.
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (b_valid_q && $past(a_go || b_valid_q)))
    else $error("counter write without a pending read");

endmodule
